// ===== src/ring_buffered_rate_scaled_playback_unit_defines.svh =====
// Assertion macros shared by the playback unit RTL.
`ifndef RING_BUFFERED_RATE_SCALED_PLAYBACK_UNIT_DEFINES_SVH
`define RING_BUFFERED_RATE_SCALED_PLAYBACK_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define RBP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("playback unit check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define RBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("playback unit check failed");

`endif

// ===== src/rbp_pkg.sv =====
// Package with the constants, codes and types of the playback unit.
package rbp_pkg;

    localparam int RING_FRAMES   = 2048;
    localparam int RING_AW       = $clog2(RING_FRAMES);
    localparam int CNT_W         = RING_AW + 1;
    localparam int REFILL_CHUNK  = 512;
    localparam int BLOCK_SAMPLES = 128;
    localparam int BLK_W         = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
    localparam int FRACTION_BITS = 16;
    localparam int RATE_W        = FRACTION_BITS + 2;
    localparam int PHASE_SUM_W   = FRACTION_BITS + 3;
    localparam int SAMPLE_W      = 16;
    localparam int STATE_W       = 3;
    localparam int UNDER_W       = 16;
    localparam int FRAMES_W      = 32;
    localparam int OP_W          = 3;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 32;

    localparam logic [RATE_W-1:0]  RATE_ONE  = RATE_W'(1) << FRACTION_BITS;
    localparam logic [RATE_W-1:0]  RATE_MAX  = RATE_W'(2) << FRACTION_BITS;
    localparam logic [UNDER_W-1:0] UNDER_MAX = '1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_RESTART = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH    = 3'd1;
    localparam logic [OP_W-1:0] OP_ENDED   = 3'd2;
    localparam logic [OP_W-1:0] OP_START   = 3'd3;
    localparam logic [OP_W-1:0] OP_PULL    = 3'd4;

    // Stream states.
    localparam logic [STATE_W-1:0] ST_IDLE     = 3'd0;
    localparam logic [STATE_W-1:0] ST_PRIMING  = 3'd1;
    localparam logic [STATE_W-1:0] ST_PRIMED   = 3'd2;
    localparam logic [STATE_W-1:0] ST_PLAYING  = 3'd3;
    localparam logic [STATE_W-1:0] ST_FINISHED = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_PLAYBACK_RATE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_FRAMES  = 1'b1;

    typedef struct packed {
        logic                 sample_valid;
        logic [STATE_W-1:0]   stream_state;
        logic [UNDER_W-1:0]   underrun_total;
        logic                 push_accepted;
        logic                 block_end;
    } rbp_status_t;

    typedef struct packed {
        logic                 we;
        logic [RING_AW-1:0]   waddr;
        logic [SAMPLE_W-1:0]  wdata;
        logic                 re;
        logic [RING_AW-1:0]   raddr;
    } rbp_mem_req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        rbp_status_t                status;
    } rbp_result_t;

endpackage

// ===== src/rbp_channels.sv =====
// Request and result channel interfaces of the playback unit.
interface rbp_req_if import rbp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output operation, output sample_in, input ready);
    modport sink (input valid, input operation, input sample_in, output ready);
endinterface

interface rbp_res_if import rbp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       sample_valid;
    logic [STATE_W-1:0]         stream_state;
    logic [UNDER_W-1:0]         underrun_total;
    logic                       push_accepted;
    logic                       block_end;

    modport source (output valid, output sample_out, output sample_valid,
                    output stream_state, output underrun_total, output push_accepted,
                    output block_end, input ready);
    modport sink (input valid, input sample_out, input sample_valid,
                  input stream_state, input underrun_total, input push_accepted,
                  input block_end, output ready);
endinterface

// ===== src/rbp_ring.sv =====
// Sample ring memory: one write port, one read port with registered read data.
module rbp_ring import rbp_pkg::*;
(
    input  logic                clk,
    input  rbp_mem_req_t        mem_req,
    output logic [SAMPLE_W-1:0] rdata
);

    logic [SAMPLE_W-1:0] mem_array [RING_FRAMES];
    logic [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem_array[mem_req.waddr] <= mem_req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_req.re)
        begin
            rdata_reg <= mem_array[mem_req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/rbp_ctrl.sv =====
// Stream control: counters, phase accumulator, block tracking and configuration.
module rbp_ctrl import rbp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [OP_W-1:0]        operation,
    input  logic [SAMPLE_W-1:0]    sample_in,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output rbp_mem_req_t           mem_req,
    output rbp_status_t            status,
    output logic [CNT_W-1:0]       buffered
);

    logic [CNT_W-1:0]         wc_reg, wc_next;
    logic [CNT_W-1:0]         rc_reg, rc_next;
    logic [FRAMES_W-1:0]      fr_reg, fr_next;
    logic [FRACTION_BITS-1:0] phase_reg, phase_next;
    logic                     eof_reg, eof_next;
    logic [STATE_W-1:0]       state_reg, state_next;
    logic [UNDER_W-1:0]       under_reg, under_next;
    logic [BLK_W-1:0]         pos_reg, pos_next;
    logic                     halted_reg, halted_next;
    logic                     reached_reg, reached_next;
    logic [RATE_W-1:0]        rate_reg, rate_next;
    logic [FRAMES_W-1:0]      total_reg, total_next;

    logic [CNT_W-1:0]         buf_after;
    logic [PHASE_SUM_W-1:0]   phase_sum;
    logic [2:0]               adv;
    logic [FRAMES_W-1:0]      fr_inc;
    logic [RATE_W-1:0]        cfg_rate;

    assign buffered  = wc_reg - rc_reg;
    assign buf_after = wc_next - rc_reg;
    assign phase_sum = PHASE_SUM_W'(phase_reg) + PHASE_SUM_W'(rate_reg);
    assign adv       = phase_sum[PHASE_SUM_W-1:FRACTION_BITS];
    assign fr_inc    = fr_reg + FRAMES_W'(1);
    assign cfg_rate  = cfg_data[RATE_W-1:0];

    always_comb
    begin
        wc_next      = wc_reg;
        rc_next      = rc_reg;
        fr_next      = fr_reg;
        phase_next   = phase_reg;
        eof_next     = eof_reg;
        state_next   = state_reg;
        under_next   = under_reg;
        pos_next     = pos_reg;
        halted_next  = halted_reg;
        reached_next = reached_reg;
        rate_next    = rate_reg;
        total_next   = total_reg;
        mem_req      = '0;
        mem_req.waddr = wc_reg[RING_AW-1:0];
        mem_req.wdata = sample_in;
        mem_req.raddr = rc_reg[RING_AW-1:0];
        status       = '0;

        if (accept)
        begin
            unique case (operation)
                OP_RESTART:
                begin
                    wc_next      = '0;
                    rc_next      = '0;
                    fr_next      = '0;
                    phase_next   = '0;
                    eof_next     = 1'b0;
                    under_next   = '0;
                    halted_next  = 1'b0;
                    reached_next = 1'b0;
                    state_next   = ST_PRIMING;
                end
                OP_PUSH:
                begin
                    if (state_reg != ST_IDLE && state_reg != ST_FINISHED && !eof_reg)
                    begin
                        if (fr_reg >= total_reg)
                        begin
                            eof_next = 1'b1;
                        end
                        else if (32'(buffered) < 32'(RING_FRAMES))
                        begin
                            mem_req.we = 1'b1;
                            wc_next    = wc_reg + CNT_W'(1);
                            fr_next    = fr_inc;
                            status.push_accepted = 1'b1;
                            if (fr_inc >= total_reg)
                            begin
                                eof_next = 1'b1;
                            end
                        end
                        if (state_reg == ST_PRIMING &&
                            (32'(buf_after) >= 32'(REFILL_CHUNK) || eof_next))
                        begin
                            state_next = ST_PRIMED;
                        end
                    end
                end
                OP_ENDED:
                begin
                    if (state_reg != ST_IDLE && state_reg != ST_FINISHED)
                    begin
                        eof_next = 1'b1;
                        if (state_reg == ST_PRIMING)
                        begin
                            state_next = ST_PRIMED;
                        end
                    end
                end
                OP_START:
                begin
                    if (state_reg == ST_PRIMED)
                    begin
                        state_next = ST_PLAYING;
                    end
                end
                OP_PULL:
                begin
                    if (state_reg == ST_PLAYING && !halted_reg)
                    begin
                        if (buffered == '0)
                        begin
                            halted_next  = 1'b1;
                            reached_next = eof_reg;
                        end
                        else if (!eof_reg && CNT_W'(adv) > buffered)
                        begin
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            // The frame under the read position goes out; the
                            // memory returns it in the next cycle.
                            mem_req.re          = 1'b1;
                            status.sample_valid = 1'b1;
                            phase_next          = phase_sum[FRACTION_BITS-1:0];
                            if (eof_reg && CNT_W'(adv) >= buffered)
                            begin
                                rc_next      = rc_reg + buffered;
                                halted_next  = 1'b1;
                                reached_next = 1'b1;
                            end
                            else
                            begin
                                rc_next = rc_reg + CNT_W'(adv);
                            end
                        end
                    end
                    if (pos_reg == BLK_W'(BLOCK_SAMPLES - 1))
                    begin
                        status.block_end = 1'b1;
                        pos_next         = '0;
                        if (state_reg == ST_PLAYING)
                        begin
                            if (reached_next)
                            begin
                                state_next = ST_FINISHED;
                            end
                            else if (halted_next && under_reg != UNDER_MAX)
                            begin
                                under_next = under_reg + UNDER_W'(1);
                            end
                        end
                        halted_next  = 1'b0;
                        reached_next = 1'b0;
                    end
                    else
                    begin
                        pos_next = pos_reg + BLK_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PLAYBACK_RATE:
                begin
                    if ((state_reg == ST_IDLE || state_reg == ST_PRIMED) &&
                        cfg_rate != '0 && cfg_rate <= RATE_MAX)
                    begin
                        rate_next = cfg_rate;
                    end
                end
                REG_TOTAL_FRAMES:
                begin
                    total_next = cfg_data[FRAMES_W-1:0];
                end
                default:
                begin
                end
            endcase
        end

        status.stream_state   = state_next;
        status.underrun_total = under_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg      <= '0;
            rc_reg      <= '0;
            fr_reg      <= '0;
            phase_reg   <= '0;
            eof_reg     <= 1'b0;
            state_reg   <= ST_IDLE;
            under_reg   <= '0;
            pos_reg     <= '0;
            halted_reg  <= 1'b0;
            reached_reg <= 1'b0;
            rate_reg    <= RATE_ONE;
            total_reg   <= '0;
        end
        else
        begin
            wc_reg      <= wc_next;
            rc_reg      <= rc_next;
            fr_reg      <= fr_next;
            phase_reg   <= phase_next;
            eof_reg     <= eof_next;
            state_reg   <= state_next;
            under_reg   <= under_next;
            pos_reg     <= pos_next;
            halted_reg  <= halted_next;
            reached_reg <= reached_next;
            rate_reg    <= rate_next;
            total_reg   <= total_next;
        end
    end

endmodule

// ===== src/rbp_outq.sv =====
// Two-entry result queue that decouples the result channel from the pipeline.
module rbp_outq import rbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  rbp_result_t push_data,
    input  logic        pop,
    output logic        not_empty,
    output rbp_result_t head,
    output logic [1:0]  level
);

    rbp_result_t slot_reg [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  level_reg, level_next;

    assign wptr_next  = push ? ~wptr_reg : wptr_reg;
    assign rptr_next  = pop ? ~rptr_reg : rptr_reg;
    assign level_next = level_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            level_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            level_reg <= level_next;
        end
    end

    assign not_empty = (level_reg != '0);
    assign head      = slot_reg[rptr_reg];
    assign level     = level_reg;

endmodule

// ===== src/ring_buffered_rate_scaled_playback_unit.sv =====
// Top level of the ring-buffered rate-scaled playback unit.
//
//  Channel   Direction  Handshake        Payload
//  req_in    in         valid / ready    operation, sample_in
//  res_out   out        valid / ready    sample_out, sample_valid, stream_state,
//                                        underrun_total, push_accepted, block_end
//  cfg       in         cfg_write only   cfg_index, cfg_data
//
// Every request produces exactly one result. Its accept updates the stream state and
// issues the ring access; the result then waits in the read stage for the registered
// ring read. A new request can be accepted every cycle while results are taken.
// Reset is asynchronous and active low; it clears all control state but leaves the
// ring contents as they are. Once two results wait in the read stage and the queue
// together, req_in.ready follows res_out.ready and stays low while no result is taken.
`include "ring_buffered_rate_scaled_playback_unit_defines.svh"

module ring_buffered_rate_scaled_playback_unit import rbp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    rbp_req_if.sink                req_in,
    rbp_res_if.source              res_out
);

    logic                accept;
    rbp_mem_req_t        mem_req;
    rbp_status_t         status;
    logic [CNT_W-1:0]    buffered;
    logic [SAMPLE_W-1:0] ring_rdata;

    // Stage between the control update and the queue. Its status is held here while
    // the registered ring read returns the data that belongs to it.
    logic        s1_valid_reg;
    rbp_status_t s1_status_reg;

    rbp_result_t q_in;
    rbp_result_t q_head;
    logic        q_not_empty;
    logic [1:0]  q_level;
    logic        pop;
    logic [1:0]  occupancy;

    assign pop       = res_out.valid && res_out.ready;
    assign occupancy = q_level + 2'(s1_valid_reg);

    // A request is taken only when a queue slot is certain to be free by the time its
    // result arrives there; a result leaving in this cycle frees one.
    assign req_in.ready = (occupancy < 2'd2) || (occupancy == 2'd2 && pop);
    assign accept       = req_in.valid && req_in.ready;

    rbp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (req_in.operation),
        .sample_in (req_in.sample_in),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mem_req   (mem_req),
        .status    (status),
        .buffered  (buffered)
    );

    // A push writes the ring at the accept edge, and a later pull reads it no earlier
    // than the next edge, so reads always see the newest data without forwarding.
    rbp_ring u_ring
    (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (ring_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status;
        end
    end

    // Silent pulls and all other operations report a zero sample.
    always_comb
    begin
        q_in.status     = s1_status_reg;
        q_in.sample_out = s1_status_reg.sample_valid ? signed'(ring_rdata) : '0;
    end

    rbp_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_data (q_in),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (q_head),
        .level     (q_level)
    );

    assign res_out.valid          = q_not_empty;
    assign res_out.sample_out     = q_head.sample_out;
    assign res_out.sample_valid   = q_head.status.sample_valid;
    assign res_out.stream_state   = q_head.status.stream_state;
    assign res_out.underrun_total = q_head.status.underrun_total;
    assign res_out.push_accepted  = q_head.status.push_accepted;
    assign res_out.block_end      = q_head.status.block_end;

    // Requests in flight never exceed the queue depth.
    `RBP_ASSERT_NOW(a_inflight_bound, 1'b1, q_level + 2'(s1_valid_reg) <= 2'd2)

    // An accepted request reaches the queue-feeding stage in the next cycle.
    `RBP_ASSERT_NEXT(a_accept_to_stage, accept, s1_valid_reg)

    // The ring never holds more frames than it has entries.
    `RBP_ASSERT_NOW(a_ring_not_overfilled, 1'b1, 32'(buffered) <= 32'(RING_FRAMES))

    // A stored push always leaves the ring with at least one buffered frame.
    `RBP_ASSERT_NEXT(a_push_fills_ring, accept && mem_req.we, buffered != '0)

endmodule

// ===== dv/ring_buffered_rate_scaled_playback_unit_tb.sv =====
// Self-checking testbench for the ring-buffered rate-scaled playback unit.
module ring_buffered_rate_scaled_playback_unit_tb import rbp_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes that the block does not decode; they only report status.
    localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

    // The longest legal quiet stretch is the deliberate hold on the result side.
    // Reset, the settle time before register writes and the random idle gaps are
    // all far shorter, so ten times that hold is a safe limit.
    localparam int unsigned RESULT_HOLD_CYCLES = 400;
    localparam int unsigned STALL_LIMIT        = 4000;
    // Each request's result passes the block's read stage and result queue;
    // the settle time is waited out once every expected result is back.
    localparam int unsigned SETTLE_CYCLES      = 4;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    rbp_req_if req_ch ();
    rbp_res_if res_ch ();

    ring_buffered_rate_scaled_playback_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_in    (req_ch),
        .res_out   (res_ch)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Stream model. It mirrors the block's state at the block's own widths
    // and is advanced once for every request, in the order of acceptance.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] ring_image [RING_FRAMES];
    logic [CNT_W-1:0]           write_ptr;
    logic [CNT_W-1:0]           read_ptr;
    logic [FRAMES_W-1:0]        frames_taken;
    logic [FRAMES_W-1:0]        frame_budget;
    logic [FRACTION_BITS-1:0]   phase_acc;
    logic                       at_eof;
    logic [STATE_W-1:0]         stream_q;
    logic [UNDER_W-1:0]         underrun_q;
    int unsigned                block_pos;
    logic                       halted_in_block;
    logic                       eof_in_block;
    logic [RATE_W-1:0]          model_rate;

    // Expected results, oldest first.
    rbp_result_t pending_results[$];

    // Bookkeeping for the checker and the closing summary.
    int unsigned failures = 0;
    int unsigned requests_sent = 0;
    int unsigned results_seen = 0;
    int unsigned streams_finished = 0;
    int unsigned full_ring_refusals = 0;
    int unsigned rate_writes_refused = 0;
    int unsigned peak_underruns = 0;
    int unsigned stall_cycles = 0;

    // Traffic shaping for the request driver and the result receiver.
    bit          idle_on = 1'b1;
    int unsigned hold_results_for = 0;

    function automatic void reset_stream_model();
        foreach (ring_image[i])
            ring_image[i] = '0;
        write_ptr       = '0;
        read_ptr        = '0;
        frames_taken    = '0;
        frame_budget    = '0;
        phase_acc       = '0;
        at_eof          = 1'b0;
        stream_q        = ST_IDLE;
        underrun_q      = '0;
        block_pos       = 0;
        halted_in_block = 1'b0;
        eof_in_block    = 1'b0;
        model_rate      = RATE_ONE;
    endfunction

    // Frames between the read and write positions; the counts run modulo
    // twice the ring size, so a plain subtraction at their width is exact.
    function automatic logic [CNT_W-1:0] frames_buffered();
        return write_ptr - read_ptr;
    endfunction

    function automatic void settle_priming();
        if (stream_q == ST_PRIMING &&
            (frames_buffered() >= CNT_W'(REFILL_CHUNK) || at_eof))
            stream_q = ST_PRIMED;
    endfunction

    // A rate write lands only while idle or primed and only with a rate
    // between one step and two frames per sample; the frame count always lands.
    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0]  data);
        logic [RATE_W-1:0] rate;
        rate = data[RATE_W-1:0];
        if (idx == REG_PLAYBACK_RATE)
        begin
            if ((stream_q == ST_IDLE || stream_q == ST_PRIMED) &&
                rate != '0 && rate <= RATE_MAX)
                model_rate = rate;
            else
                rate_writes_refused++;
        end
        else
            frame_budget = data;
    endfunction

    // Advances the stream model by one request and returns the result that
    // the block must send back for it.
    function automatic rbp_result_t playback_step(input logic [OP_W-1:0]     op,
                                                  input logic [SAMPLE_W-1:0] value);
        rbp_result_t            res;
        logic [CNT_W-1:0]       avail;
        logic [CNT_W-1:0]       adv;
        logic [PHASE_SUM_W-1:0] phase_next;
        res = '0;
        case (op)
            OP_RESTART:
            begin
                // The block position is the audio clock and survives a restart.
                write_ptr       = '0;
                read_ptr        = '0;
                frames_taken    = '0;
                phase_acc       = '0;
                at_eof          = 1'b0;
                underrun_q      = '0;
                halted_in_block = 1'b0;
                eof_in_block    = 1'b0;
                stream_q        = ST_PRIMING;
            end
            OP_PUSH:
            begin
                if (stream_q != ST_IDLE && stream_q != ST_FINISHED && !at_eof)
                begin
                    if (frames_taken >= frame_budget)
                        at_eof = 1'b1;
                    else if (frames_buffered() < CNT_W'(RING_FRAMES))
                    begin
                        ring_image[write_ptr[RING_AW-1:0]] = value;
                        write_ptr    = write_ptr + CNT_W'(1);
                        frames_taken = frames_taken + FRAMES_W'(1);
                        res.status.push_accepted = 1'b1;
                        if (frames_taken >= frame_budget)
                            at_eof = 1'b1;
                    end
                    else
                        full_ring_refusals++;
                    settle_priming();
                end
            end
            OP_ENDED:
            begin
                if (stream_q != ST_IDLE && stream_q != ST_FINISHED)
                begin
                    at_eof = 1'b1;
                    settle_priming();
                end
            end
            OP_START:
            begin
                if (stream_q == ST_PRIMED)
                    stream_q = ST_PLAYING;
            end
            OP_PULL:
            begin
                if (stream_q == ST_PLAYING && !halted_in_block)
                begin
                    avail = frames_buffered();
                    if (avail == '0)
                    begin
                        halted_in_block = 1'b1;
                        eof_in_block    = at_eof;
                    end
                    else
                    begin
                        phase_next = PHASE_SUM_W'(phase_acc) + PHASE_SUM_W'(model_rate);
                        adv        = CNT_W'(phase_next >> FRACTION_BITS);
                        if (!at_eof && adv > avail)
                            halted_in_block = 1'b1;
                        else
                        begin
                            res.sample_out          = ring_image[read_ptr[RING_AW-1:0]];
                            res.status.sample_valid = 1'b1;
                            phase_acc               = phase_next[FRACTION_BITS-1:0];
                            // Running off the end of a finished source stops at
                            // the write position and silences the block.
                            if (at_eof && adv >= avail)
                            begin
                                read_ptr        = read_ptr + avail;
                                halted_in_block = 1'b1;
                                eof_in_block    = 1'b1;
                            end
                            else
                                read_ptr = read_ptr + adv;
                        end
                    end
                end
                block_pos++;
                if (block_pos >= BLOCK_SAMPLES)
                begin
                    res.status.block_end = 1'b1;
                    block_pos = 0;
                    if (stream_q == ST_PLAYING)
                    begin
                        if (eof_in_block)
                        begin
                            stream_q = ST_FINISHED;
                            streams_finished++;
                        end
                        else if (halted_in_block && underrun_q != UNDER_MAX)
                            underrun_q = underrun_q + UNDER_W'(1);
                    end
                    halted_in_block = 1'b0;
                    eof_in_block    = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        if (32'(underrun_q) > peak_underruns)
            peak_underruns = 32'(underrun_q);
        res.status.stream_state   = stream_q;
        res.status.underrun_total = underrun_q;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request driver. Inputs change on the falling edge; acceptance is seen
    // on the rising edge, where the model is advanced and the expected
    // result is queued. Valid stays high after acceptance until the next
    // falling edge, where it either carries the next request or drops.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [OP_W-1:0]     op,
                                input logic [SAMPLE_W-1:0] value);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 36)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.sample_in <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(playback_step(op, value));
        requests_sent++;
    endtask

    // Stops offering requests and waits until every expected result is back,
    // then lets the block settle.
    task automatic wait_for_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Registers are only touched while the block has nothing in flight.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0]  data);
        wait_for_results();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        apply_register(idx, data);
    endtask

    // A rate word drawn from the extremes, the range around unity, the full
    // legal range and the illegal values; upper bits beyond the rate field
    // are sometimes set, since the block must ignore them.
    function automatic logic [CFG_DATA_W-1:0] random_rate_word();
        logic [CFG_DATA_W-1:0] word;
        case ($urandom_range(6))
            0:       word = CFG_DATA_W'(1);
            1:       word = CFG_DATA_W'(RATE_ONE);
            2:       word = CFG_DATA_W'(RATE_MAX);
            3:       word = $urandom_range(1, RATE_MAX);
            4:       word = $urandom_range(RATE_ONE / 2, RATE_ONE + RATE_ONE / 2);
            5:       word = $urandom_range(RATE_MAX + 1, {RATE_W{1'b1}});
            default: word = '0;
        endcase
        if ($urandom_range(3) == 0)
            word[CFG_DATA_W-1:RATE_W] = (CFG_DATA_W - RATE_W)'($urandom);
        return word;
    endfunction

    // ------------------------------------------------------------------
    // Result receiver. Ready changes on the falling edge. A hold request
    // from a test keeps ready low for a counted stretch so that the block's
    // result queue fills and it stops taking requests.
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_results_for != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (hold_results_for) @(negedge clk);
                hold_results_for = 0;
            end
            res_ch.ready <= !(idle_on && $urandom_range(99) < 36);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Every accepted result is matched against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        rbp_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                failures++;
                $display("%0t: result with no request waiting, expected none, got %0h",
                         $time, res_ch.sample_out);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("sample_out", 32'(want.sample_out), 32'(res_ch.sample_out));
                check_field("sample_valid", 32'(want.status.sample_valid),
                            32'(res_ch.sample_valid));
                check_field("stream_state", 32'(want.status.stream_state),
                            32'(res_ch.stream_state));
                check_field("underrun_total", 32'(want.status.underrun_total),
                            32'(res_ch.underrun_total));
                check_field("push_accepted", 32'(want.status.push_accepted),
                            32'(res_ch.push_accepted));
                check_field("block_end", 32'(want.status.block_end),
                            32'(res_ch.block_end));
            end
        end
    end

    // Watchdog: a run in which nothing moves for too long has hung.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: nothing accepted for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Out of reset the stream is idle: pushes, source ended, start and pulls
    // have no effect apart from the pull advancing the audio clock, and the
    // undecoded operations only report status. Rate writes of zero, of just
    // over two frames per sample and of all ones are refused; the top rate
    // is taken.
    task automatic test_idle_requests();
        send_request(OP_PUSH, 16'h7FFF);
        send_request(OP_ENDED, 16'h0000);
        send_request(OP_START, 16'hFFFF);
        send_request(OP_PULL, 16'h8000);
        send_request(OP_UNUSED_LO, 16'h5555);
        send_request(OP_UNUSED_MID, 16'hAAAA);
        send_request(OP_UNUSED_HI, 16'hFFFF);
        write_register(REG_PLAYBACK_RATE, '0);
        write_register(REG_PLAYBACK_RATE, CFG_DATA_W'(RATE_MAX) + 1);
        write_register(REG_PLAYBACK_RATE, '1);
        write_register(REG_PLAYBACK_RATE, CFG_DATA_W'(RATE_MAX));
    endtask

    // A stream with no frames at all reaches end of file on its first push
    // and primes at once; start is ignored while still priming. Then a
    // four-frame stream with the sample extremes plays out at unity rate,
    // with pushes after end of file ignored and the last pull going silent.
    task automatic test_short_stream();
        send_request(OP_RESTART, 16'h0000);
        send_request(OP_START, 16'h0000);
        send_request(OP_PUSH, 16'h1234);
        send_request(OP_PUSH, 16'h4321);
        write_register(REG_PLAYBACK_RATE, CFG_DATA_W'(RATE_ONE));
        write_register(REG_TOTAL_FRAMES, CFG_DATA_W'(4));
        send_request(OP_RESTART, 16'h0000);
        send_request(OP_PUSH, 16'h8000);
        send_request(OP_PUSH, 16'h7FFF);
        send_request(OP_PUSH, 16'h0000);
        send_request(OP_PUSH, 16'hFFFF);
        send_request(OP_PUSH, 16'h0005);
        send_request(OP_ENDED, 16'h0000);
        send_request(OP_START, 16'h0000);
        repeat (5) send_request(OP_PULL, 16'h0000);
    endtask

    // Rate writes are refused while playing, priming and finished, and taken
    // while primed. A stream that ends before its first frame halts on its
    // first pull and finishes at the next block boundary; after that pushes,
    // source ended and start do nothing.
    task automatic test_rate_writes_outside_idle();
        write_register(REG_PLAYBACK_RATE, CFG_DATA_W'(RATE_ONE));
        send_request(OP_RESTART, 16'h0000);
        write_register(REG_PLAYBACK_RATE, CFG_DATA_W'(3));
        send_request(OP_ENDED, 16'h0000);
        write_register(REG_PLAYBACK_RATE, CFG_DATA_W'(1));
        send_request(OP_START, 16'h0000);
        do
        begin
            send_request(OP_PULL, SAMPLE_W'($urandom));
        end
        while (stream_q != ST_FINISHED);
        write_register(REG_PLAYBACK_RATE, CFG_DATA_W'(RATE_ONE));
        send_request(OP_PUSH, SAMPLE_W'($urandom));
        send_request(OP_ENDED, SAMPLE_W'($urandom));
        send_request(OP_START, SAMPLE_W'($urandom));
        send_request(OP_PULL, SAMPLE_W'($urandom));
    endtask

    // A short stream is pushed with no idling while the result side is held
    // off, so the block's result queue backs up and stalls its request side;
    // pushes after the last frame are ignored. The stream then plays at two
    // frames per sample until it runs off its last frame and goes silent.
    task automatic test_ring_fill_and_wrap();
        int i;
        idle_on = 1'b0;
        write_register(REG_TOTAL_FRAMES, CFG_DATA_W'(40));
        send_request(OP_RESTART, 16'h0000);
        hold_results_for = RESULT_HOLD_CYCLES;
        for (i = 0; i < 42; i++)
            send_request(OP_PUSH, SAMPLE_W'($urandom));
        write_register(REG_PLAYBACK_RATE, CFG_DATA_W'(RATE_MAX));
        send_request(OP_START, 16'h0000);
        idle_on = 1'b1;
        for (i = 0; i < 24; i++)
            send_request(OP_PULL, SAMPLE_W'($urandom));
    endtask

    // Random streams: short restart, push, start and pull sequences with
    // random frame counts, rates and samples, salted with pushes during
    // playback, stray operations and the odd restart midway.
    task automatic test_random_streams();
        int unsigned first_request;
        int unsigned push_count;
        int unsigned pull_count;
        int unsigned pick;
        int unsigned i;
        logic [FRAMES_W-1:0] budget;
        first_request = requests_sent;
        while (requests_sent - first_request < 180)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                budget = $urandom_range(0, 48);
            else
                budget = '1;
            write_register(REG_TOTAL_FRAMES, budget);
            write_register(REG_PLAYBACK_RATE, random_rate_word());
            send_request(OP_RESTART, SAMPLE_W'($urandom));
            push_count = (budget <= 48) ? budget + $urandom_range(0, 2)
                                        : $urandom_range(0, 48);
            for (i = 0; i < push_count; i++)
            begin
                if ($urandom_range(99) < 3)
                    send_request(OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
                                 SAMPLE_W'($urandom));
                send_request(OP_PUSH, SAMPLE_W'($urandom));
            end
            if (stream_q == ST_PRIMING || $urandom_range(99) < 40)
                send_request(OP_ENDED, SAMPLE_W'($urandom));
            // Sometimes retune while primed, where the block takes any legal rate.
            if ($urandom_range(1) == 1)
                write_register(REG_PLAYBACK_RATE, random_rate_word());
            send_request(OP_START, SAMPLE_W'($urandom));
            pull_count = $urandom_range(10, 80);
            for (i = 0; i < pull_count; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 12)
                    send_request(OP_PUSH, SAMPLE_W'($urandom));
                else if (pick < 14)
                    send_request(OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
                                 SAMPLE_W'($urandom));
                else if (pick < 15)
                    send_request(OP_START, SAMPLE_W'($urandom));
                else if (pick < 16)
                    send_request(OP_ENDED, SAMPLE_W'($urandom));
                else if (pick < 17)
                    send_request(OP_RESTART, SAMPLE_W'($urandom));
                else
                    send_request(OP_PULL, SAMPLE_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------
    initial
    begin
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_RESTART;
        req_ch.sample_in = '0;
        res_ch.ready     = 1'b0;
        reset_stream_model();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_requests();
        test_short_stream();
        test_rate_writes_outside_idle();
        test_ring_fill_and_wrap();
        test_random_streams();

        wait_for_results();
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            failures++;
            $display("%0t: %0d results never arrived", $time, pending_results.size());
        end

        $display("Run covered %0d requests and %0d results; %0d streams played to the end.",
                 requests_sent, results_seen, streams_finished);
        $display("Full-ring pushes refused: %0d, rate writes refused: %0d, peak underruns: %0d.",
                 full_ring_refusals, rate_writes_refused, peak_underruns);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
